@@ src/pkfe_pkg.sv @@
// pkfe_pkg: shared constants, register indexes, op codes and types for the
// packet key field extractor. No dependencies; used by every module in src.
package pkfe_pkg;

    // key and entry geometry
    localparam int KEY_BYTES      = 8;
    localparam int MAX_ENTRIES    = 4;
    localparam int OFFSET_BITS    = 12;
    localparam int NUM_ENTRY_REGS = 4;

    // entry word layout: source, source offset, key offset, size
    localparam int KOFF_W      = 3;
    localparam int SIZE_W      = 4;
    localparam int SRC_BIT     = 0;
    localparam int OFF_LSB     = 1;
    localparam int KOFF_LSB    = OFFSET_BITS + 1;
    localparam int SIZE_LSB    = KOFF_LSB + KOFF_W;
    localparam int ENTRY_W     = SIZE_LSB + SIZE_W;
    localparam int ENTRY_CNT_W = 3;
    localparam int MASK_W      = 64;

    // per-source byte counters saturate at all ones
    localparam int                POS_W   = 13;
    localparam logic [POS_W-1:0]  POS_MAX = {POS_W{1'b1}};

    // widths for the offset arithmetic
    localparam int END_W  = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;
    localparam int CMP_W  = (END_W > POS_W) ? END_W : POS_W;
    localparam int KIDX_W = ((KOFF_W > SIZE_W) ? KOFF_W : SIZE_W) + 1;

    // stream field widths
    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int KEY_W  = KEY_BYTES * BYTE_W;

    // op codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_PACKET   = 2'd0;
    localparam logic [OP_W-1:0] OP_METADATA = 2'd1;
    localparam logic [OP_W-1:0] OP_END      = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_BOUNDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_WORD_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_WORD_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_WORD_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_WORD_3 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MASK     = 3'd6;

    // configuration register file contents
    typedef struct packed {
        logic                                     check_bounds;
        logic [ENTRY_CNT_W-1:0]                   entry_count;
        logic [NUM_ENTRY_REGS-1:0][ENTRY_W-1:0]   entry_word;
        logic [MASK_W-1:0]                        key_byte_mask;
    } cfg_t;

    // entry matcher output: key byte write enables and per-source length needs
    typedef struct packed {
        logic [KEY_BYTES-1:0] byte_we;
        logic [CMP_W-1:0]     need_pkt;
        logic [CMP_W-1:0]     need_meta;
    } match_t;

endpackage

@@ src/packet_key_field_extractor.sv @@
// packet_key_field_extractor: top level with input register, record state
// and result register. Uses pkfe_pkg, pkfe_cfg_regs and pkfe_entry_match.
//
// Takes one packet, metadata or end-of-record word per clock, except while an
// end-of-record word waits on a stalled result, and for each end-of-record
// word returns one word carrying the masked key and its valid flag.
// Throughput is one word per cycle on both sides while m_tready stays high.
// An accepted end-of-record word passes the input register, waiting there
// while an earlier result is untaken, and then loads the result register.
// Entry matching is combinational, after the input register. A stalled result
// holds the input only once an end-of-record word is in the input register;
// source bytes flow until then. There is no clearing pass after reset.
// Configuration writes are always accepted and must only be issued while no
// record result is pending.
module packet_key_field_extractor (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pkfe_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] byte_value
    input  logic [pkfe_pkg::OP_W-1:0]       s_tuser,   // [1:0] op
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pkfe_pkg::KEY_W-1:0]      m_tdata,   // [63:0] key_value
    output logic                            m_tuser,   // [0] key_valid
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pkfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pkfe_pkg::MASK_W-1:0]     cfg_data
);

    pkfe_pkg::cfg_t   cfg;
    pkfe_pkg::match_t match;

    logic                                            in_valid_reg;
    logic [pkfe_pkg::OP_W-1:0]                       in_op_reg;
    logic [pkfe_pkg::BYTE_W-1:0]                     in_byte_reg;
    logic [pkfe_pkg::POS_W-1:0]                      pkt_pos_reg;
    logic [pkfe_pkg::POS_W-1:0]                      pkt_pos_next;
    logic [pkfe_pkg::POS_W-1:0]                      meta_pos_reg;
    logic [pkfe_pkg::POS_W-1:0]                      meta_pos_next;
    logic [pkfe_pkg::KEY_BYTES-1:0][pkfe_pkg::BYTE_W-1:0] key_bytes_reg;
    logic [pkfe_pkg::KEY_BYTES-1:0][pkfe_pkg::BYTE_W-1:0] key_bytes_next;
    logic                                            out_valid_reg;
    logic                                            out_valid_next;
    logic [pkfe_pkg::KEY_W-1:0]                      out_key_reg;
    logic                                            out_flag_reg;

    logic                                            out_free;
    logic                                            is_src;
    logic                                            is_end;
    logic                                            advance;
    logic [pkfe_pkg::POS_W-1:0]                      cur_pos;
    logic                                            rec_valid;
    logic [pkfe_pkg::KEY_W-1:0]                      rec_key;

    pkfe_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // word decode and flow control
    assign is_src   = (in_op_reg == pkfe_pkg::OP_PACKET) ||
                      (in_op_reg == pkfe_pkg::OP_METADATA);
    assign is_end   = (in_op_reg == pkfe_pkg::OP_END);
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!is_end || out_free);
    assign s_tready = !in_valid_reg || advance;

    // position of the source this byte belongs to
    assign cur_pos = in_op_reg[0] ? meta_pos_reg : pkt_pos_reg;

    pkfe_entry_match u_entry_match (
        .cfg    (cfg),
        .src    (in_op_reg[0]),
        .pos    (cur_pos),
        .result (match)
    );

    // length check and masked key for the closing record
    always_comb begin
        rec_valid = !cfg.check_bounds ||
                    ((pkfe_pkg::CMP_W'(pkt_pos_reg) >= match.need_pkt) &&
                     (pkfe_pkg::CMP_W'(meta_pos_reg) >= match.need_meta));
        rec_key = '0;
        for (int j = 0; j < pkfe_pkg::KEY_BYTES; j++) begin
            rec_key[j*pkfe_pkg::BYTE_W +: pkfe_pkg::BYTE_W] = rec_valid ?
                (key_bytes_reg[j] & cfg.key_byte_mask[j*pkfe_pkg::BYTE_W +: pkfe_pkg::BYTE_W])
                : '0;
        end
    end

    // record state update
    always_comb begin
        pkt_pos_next   = pkt_pos_reg;
        meta_pos_next  = meta_pos_reg;
        key_bytes_next = key_bytes_reg;
        if (advance && is_end) begin
            pkt_pos_next   = '0;
            meta_pos_next  = '0;
            key_bytes_next = '0;
        end else if (advance && is_src && (cur_pos != pkfe_pkg::POS_MAX)) begin
            for (int j = 0; j < pkfe_pkg::KEY_BYTES; j++) begin
                if (match.byte_we[j]) key_bytes_next[j] = in_byte_reg;
            end
            if (in_op_reg[0]) meta_pos_next = cur_pos + pkfe_pkg::POS_W'(1);
            else              pkt_pos_next  = cur_pos + pkfe_pkg::POS_W'(1);
        end
    end

    // result valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && is_end)  out_valid_next = 1'b1;
        else if (m_tready)      out_valid_next = 1'b0;
    end

    // control and record state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pkt_pos_reg   <= '0;
            meta_pos_reg  <= '0;
            key_bytes_reg <= '0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
            pkt_pos_reg   <= pkt_pos_next;
            meta_pos_reg  <= meta_pos_next;
            key_bytes_reg <= key_bytes_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance && is_end) begin
            out_key_reg  <= rec_key;
            out_flag_reg <= rec_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_key_reg;
    assign m_tuser  = out_flag_reg;

    // closing word always produces a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_end |=> out_valid_reg)
        else $error("end word did not load the result register");

    // record state is cleared after each closing word
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_end |=> (pkt_pos_reg == '0) && (meta_pos_reg == '0)
                              && (key_bytes_reg == '0))
        else $error("record state not cleared after end word");

    // a failed record never carries key bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_flag_reg |-> out_key_reg == '0)
        else $error("invalid record with nonzero key");

    // a saturated counter stays put until the record closes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pkt_pos_reg == pkfe_pkg::POS_MAX) && !(advance && is_end)
        |=> pkt_pos_reg == pkfe_pkg::POS_MAX)
        else $error("packet position moved past saturation");

    // a held word is not dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_op_reg))
        else $error("stalled input word lost");

endmodule

@@ src/pkfe_cfg_regs.sv @@
// pkfe_cfg_regs: configuration register file written over the cfg channel.
// Depends on pkfe_pkg for register indexes and the cfg_t layout.
module pkfe_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pkfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pkfe_pkg::MASK_W-1:0]     cfg_data,
    output pkfe_pkg::cfg_t                  cfg
);

    pkfe_pkg::cfg_t cfg_reg;
    pkfe_pkg::cfg_t cfg_next;

    // register writes never stall
    assign cfg_ready = 1'b1;
    assign cfg     = cfg_reg;

    // index decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pkfe_pkg::REG_CHECK_BOUNDS: cfg_next.check_bounds = cfg_data[0];
                pkfe_pkg::REG_ENTRY_COUNT:
                    cfg_next.entry_count = cfg_data[pkfe_pkg::ENTRY_CNT_W-1:0];
                pkfe_pkg::REG_ENTRY_WORD_0:
                    cfg_next.entry_word[0] = cfg_data[pkfe_pkg::ENTRY_W-1:0];
                pkfe_pkg::REG_ENTRY_WORD_1:
                    cfg_next.entry_word[1] = cfg_data[pkfe_pkg::ENTRY_W-1:0];
                pkfe_pkg::REG_ENTRY_WORD_2:
                    cfg_next.entry_word[2] = cfg_data[pkfe_pkg::ENTRY_W-1:0];
                pkfe_pkg::REG_ENTRY_WORD_3:
                    cfg_next.entry_word[3] = cfg_data[pkfe_pkg::ENTRY_W-1:0];
                pkfe_pkg::REG_KEY_MASK:     cfg_next.key_byte_mask = cfg_data;
                default: ;
            endcase
        end
    end

    // register file, reset to bounds checking on, no entries, all-ones mask
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.check_bounds  <= 1'b1;
            cfg_reg.entry_count   <= '0;
            cfg_reg.entry_word    <= '0;
            cfg_reg.key_byte_mask <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/pkfe_entry_match.sv @@
// pkfe_entry_match: compares one source byte position against all extract
// entries in parallel and computes per-source length needs. Uses pkfe_pkg.
module pkfe_entry_match (
    input  pkfe_pkg::cfg_t                  cfg,
    input  logic                            src,
    input  logic [pkfe_pkg::POS_W-1:0]      pos,
    output pkfe_pkg::match_t                result
);

    always_comb begin
        logic [pkfe_pkg::ENTRY_W-1:0]  w;
        logic                          active;
        logic [pkfe_pkg::CMP_W-1:0]    off_x;
        logic [pkfe_pkg::CMP_W-1:0]    size_x;
        logic [pkfe_pkg::CMP_W-1:0]    end_x;
        logic [pkfe_pkg::CMP_W-1:0]    pos_x;
        logic [pkfe_pkg::CMP_W-1:0]    diff;
        logic                          hit;
        logic [pkfe_pkg::KIDX_W-1:0]   kidx;

        result = '0;
        pos_x  = pkfe_pkg::CMP_W'(pos);
        // enables of all matching entries are ORed together on each key byte
        for (int i = 0; i < pkfe_pkg::MAX_ENTRIES; i++) begin
            w      = cfg.entry_word[i];
            active = cfg.entry_count > pkfe_pkg::ENTRY_CNT_W'(i);
            off_x  = pkfe_pkg::CMP_W'(w[pkfe_pkg::OFF_LSB +: pkfe_pkg::OFFSET_BITS]);
            size_x = pkfe_pkg::CMP_W'(w[pkfe_pkg::SIZE_LSB +: pkfe_pkg::SIZE_W]);
            end_x  = off_x + size_x;
            diff   = pos_x - off_x;
            hit    = active && (w[pkfe_pkg::SRC_BIT] == src) && (pos_x >= off_x)
                     && (diff < size_x);
            kidx   = pkfe_pkg::KIDX_W'(w[pkfe_pkg::KOFF_LSB +: pkfe_pkg::KOFF_W])
                     + pkfe_pkg::KIDX_W'(diff[pkfe_pkg::SIZE_W-1:0]);

            // furthest byte each source must deliver
            if (active) begin
                if (w[pkfe_pkg::SRC_BIT]) begin
                    if (end_x > result.need_meta) result.need_meta = end_x;
                end else begin
                    if (end_x > result.need_pkt) result.need_pkt = end_x;
                end
            end

            // key positions past the key width get no enable
            for (int j = 0; j < pkfe_pkg::KEY_BYTES; j++) begin
                if (hit && (kidx == pkfe_pkg::KIDX_W'(j))) result.byte_we[j] = 1'b1;
            end
        end
    end

endmodule
